FILE: rtl/rsnep_pkg.sv
// Package for the RSN element parser: payload types, phase codes and status codes.
package rsnep_pkg;

  localparam int unsigned HDR_LEN = 2;
  localparam logic [7:0]  RSN_TAG        = 8'd48;
  localparam logic [15:0] VERSION_ONE    = 16'h0001;

  localparam logic [7:0] PREFIX_0 = 8'h00;
  localparam logic [7:0] PREFIX_1 = 8'h0f;
  localparam logic [7:0] PREFIX_2 = 8'hac;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_TAG       = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_SUITE     = 3'd4;
  localparam logic [2:0] ST_ZERO      = 3'd5;

  localparam logic [2:0]  GROUP_DEFAULT    = 3'd4;
  localparam logic [5:0]  PAIRWISE_DEFAULT = 6'b01_0000;
  localparam logic [9:0]  AKM_DEFAULT      = 10'b00_0000_0010;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_GROUP   = 3'd1,
    PH_PCOUNT  = 3'd2,
    PH_PLIST   = 3'd3,
    PH_ACOUNT  = 3'd4,
    PH_ALIST   = 3'd5,
    PH_CAPS    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  group_suite;
    logic [5:0]  pairwise_mask;
    logic [9:0]  akm_mask;
    logic [13:0] capabilities;
  } out_t;

endpackage

FILE: rtl/rsn_element_parser_top.sv
// RSN security element parser: streams buffer bytes and returns one verdict per buffer.
//
// Input channel (in_valid/in_stall/in_data): one buffer byte per transaction,
// tag first, then length, then the element body; last_byte marks the final
// byte of the buffer. Output channel (out_valid/out_stall/out_data): one
// transaction per buffer carrying status, group cipher, suite masks and
// capabilities (all zero unless status is ok).
// Throughput is one byte per cycle while in_stall is low: each byte updates
// the parse state in the cycle it is accepted. The verdict appears in the
// output register in the cycle after the last byte is accepted. While a
// verdict is held by a stalled receiver, bytes that are not last are still
// accepted; a last byte stalls until the output register frees up, which it
// does in the cycle it drains. Reset (rst_n low, synchronous) empties the
// output register and returns the parser to the start of a buffer; the
// parser also returns there by itself after each last byte.
module rsn_element_parser_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rsnep_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rsnep_pkg::out_t out_data
);

  logic [8:0]        byte_count_r, byte_count_nxt;
  logic [7:0]        tag_r, tag_nxt;
  logic [7:0]        len_r, len_nxt;
  rsnep_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        fbi_r, fbi_nxt;
  logic [7:0]        count_low_r, count_low_nxt;
  logic [5:0]        suites_left_r, suites_left_nxt;
  logic              prefix_match_r, prefix_match_nxt;
  logic [2:0]        error_r, error_nxt;
  logic [2:0]        group_r, group_nxt;
  logic [5:0]        pairwise_r, pairwise_nxt;
  logic [9:0]        akm_r, akm_nxt;
  logic [13:0]       caps_r, caps_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsnep_pkg::out_t   out_data_r, out_data_nxt;

  logic in_accept;

  function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = rsnep_pkg::PREFIX_0;
      2'd1:    v = rsnep_pkg::PREFIX_1;
      default: v = rsnep_pkg::PREFIX_2;
    endcase
    return v;
  endfunction

  function automatic logic group_ok(input logic [7:0] t);
    return (t == 8'd1) || (t == 8'd2) || (t == 8'd4) || (t == 8'd5) || (t == 8'd7);
  endfunction

  function automatic logic pairwise_ok(input logic [7:0] t);
    return (t == 8'd0) || (t == 8'd1) || (t == 8'd2) || (t == 8'd4) || (t == 8'd5);
  endfunction

  function automatic logic akm_ok(input logic [7:0] t);
    return (t >= 8'd1) && (t <= 8'd9);
  endfunction

  assign in_stall  = out_valid_r && out_stall && in_data.last_byte;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  rem;
    logic [7:0]  rem_after;
    logic        at_start;
    logic        pm_eff;
    logic [15:0] count;
    logic [5:0]  left_dec;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        short_buf;
    logic [2:0]  status;

    byte_count_nxt   = byte_count_r;
    tag_nxt          = tag_r;
    len_nxt          = len_r;
    phase_nxt        = phase_r;
    fbi_nxt          = fbi_r;
    count_low_nxt    = count_low_r;
    suites_left_nxt  = suites_left_r;
    prefix_match_nxt = prefix_match_r;
    error_nxt        = error_r;
    group_nxt        = group_r;
    pairwise_nxt     = pairwise_r;
    akm_nxt          = akm_r;
    caps_nxt         = caps_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    b         = in_data.data_byte;
    rem       = 8'(({1'b0, len_r} + 9'(rsnep_pkg::HDR_LEN)) - byte_count_r);
    rem_after = rem - 8'd1;
    at_start  = (fbi_r == 2'd0);
    pm_eff    = at_start ? 1'b1 : prefix_match_r;
    count     = {b, count_low_r};
    left_dec  = suites_left_r - 6'd1;
    fail_en   = 1'b0;
    fail_code = rsnep_pkg::ST_OK;
    short_buf = 1'b0;
    status    = rsnep_pkg::ST_OK;

    if (in_accept) begin
      if (byte_count_r == 9'd0) begin
        tag_nxt = b;
      end else if (byte_count_r == 9'd1) begin
        len_nxt = b;
        if (b < 8'd2) begin
          fail_en   = 1'b1;
          fail_code = rsnep_pkg::ST_SHORT;
        end
      end else if ({1'b0, byte_count_r} <
                   10'(rsnep_pkg::HDR_LEN) + {2'b00, len_r}) begin
        unique case (phase_r)
          rsnep_pkg::PH_VERSION: begin
            if (at_start) begin
              count_low_nxt = b;
              fbi_nxt       = 2'd1;
            end else if (count != rsnep_pkg::VERSION_ONE) begin
              fail_en   = 1'b1;
              fail_code = rsnep_pkg::ST_MALFORMED;
            end else begin
              fbi_nxt   = 2'd0;
              phase_nxt = (rem_after == 8'd0) ? rsnep_pkg::PH_DONE : rsnep_pkg::PH_GROUP;
            end
          end
          rsnep_pkg::PH_GROUP: begin
            if (at_start && rem < 8'd4) begin
              fail_en   = 1'b1;
              fail_code = rsnep_pkg::ST_MALFORMED;
            end else if (fbi_r != 2'd3) begin
              prefix_match_nxt = pm_eff && (b == prefix_byte(fbi_r));
              fbi_nxt          = fbi_r + 2'd1;
            end else if (!pm_eff || !group_ok(b)) begin
              fail_en   = 1'b1;
              fail_code = rsnep_pkg::ST_SUITE;
            end else begin
              group_nxt = b[2:0];
              fbi_nxt   = 2'd0;
              phase_nxt = (rem_after == 8'd0) ? rsnep_pkg::PH_DONE : rsnep_pkg::PH_PCOUNT;
            end
          end
          rsnep_pkg::PH_PCOUNT, rsnep_pkg::PH_ACOUNT: begin
            if (at_start) begin
              if (rem < 8'd2) begin
                fail_en   = 1'b1;
                fail_code = rsnep_pkg::ST_MALFORMED;
              end else begin
                count_low_nxt = b;
                fbi_nxt       = 2'd1;
              end
            end else begin
              fbi_nxt = 2'd0;
              if (count == 16'd0) begin
                fail_en   = 1'b1;
                fail_code = rsnep_pkg::ST_ZERO;
              end else if (count > {10'd0, rem_after[7:2]}) begin
                // count * 4 exceeds what is left of the body
                fail_en   = 1'b1;
                fail_code = rsnep_pkg::ST_MALFORMED;
              end else begin
                suites_left_nxt = count[5:0];
                if (phase_r == rsnep_pkg::PH_PCOUNT) begin
                  phase_nxt    = rsnep_pkg::PH_PLIST;
                  pairwise_nxt = 6'd0;
                end else begin
                  phase_nxt = rsnep_pkg::PH_ALIST;
                  akm_nxt   = 10'd0;
                end
              end
            end
          end
          rsnep_pkg::PH_PLIST, rsnep_pkg::PH_ALIST: begin
            if (fbi_r != 2'd3) begin
              prefix_match_nxt = pm_eff && (b == prefix_byte(fbi_r));
              fbi_nxt          = fbi_r + 2'd1;
            end else if (!pm_eff ||
                         ((phase_r == rsnep_pkg::PH_PLIST) ? !pairwise_ok(b) : !akm_ok(b))) begin
              fail_en   = 1'b1;
              fail_code = rsnep_pkg::ST_SUITE;
            end else begin
              if (phase_r == rsnep_pkg::PH_PLIST) begin
                pairwise_nxt = pairwise_r | (6'd1 << b[2:0]);
              end else begin
                akm_nxt = akm_r | (10'd1 << b[3:0]);
              end
              fbi_nxt         = 2'd0;
              suites_left_nxt = left_dec;
              if (left_dec == 6'd0) begin
                if (rem_after == 8'd0) begin
                  phase_nxt = rsnep_pkg::PH_DONE;
                end else if (phase_r == rsnep_pkg::PH_PLIST) begin
                  phase_nxt = rsnep_pkg::PH_ACOUNT;
                end else begin
                  phase_nxt = rsnep_pkg::PH_CAPS;
                end
              end
            end
          end
          rsnep_pkg::PH_CAPS: begin
            if (at_start) begin
              if (rem < 8'd2) begin
                fail_en   = 1'b1;
                fail_code = rsnep_pkg::ST_MALFORMED;
              end else begin
                caps_nxt = {6'd0, b};
                fbi_nxt  = 2'd1;
              end
            end else begin
              caps_nxt  = {caps_r[13:9] | b[5:1], caps_r[8:0]};
              fbi_nxt   = 2'd0;
              phase_nxt = rsnep_pkg::PH_DONE;
            end
          end
          rsnep_pkg::PH_DONE: begin
          end
          default: begin
          end
        endcase
      end

      // keep the first error; any error ends the parse
      if (fail_en) begin
        if (error_r == rsnep_pkg::ST_OK) begin
          error_nxt = fail_code;
        end
        phase_nxt = rsnep_pkg::PH_DONE;
      end

      if (byte_count_r != 9'h1ff) begin
        byte_count_nxt = byte_count_r + 9'd1;
      end

      if (in_data.last_byte) begin
        short_buf = (byte_count_nxt < 9'(rsnep_pkg::HDR_LEN)) ||
                    ({1'b0, byte_count_nxt} <
                     10'(rsnep_pkg::HDR_LEN) + {2'b00, len_nxt});
        if (short_buf) begin
          status = rsnep_pkg::ST_SHORT;
        end else if (tag_nxt != rsnep_pkg::RSN_TAG) begin
          status = rsnep_pkg::ST_TAG;
        end else begin
          status = error_nxt;
        end

        out_valid_nxt       = 1'b1;
        out_data_nxt.status = status;
        if (status == rsnep_pkg::ST_OK) begin
          out_data_nxt.group_suite   = group_nxt;
          out_data_nxt.pairwise_mask = pairwise_nxt;
          out_data_nxt.akm_mask      = akm_nxt;
          out_data_nxt.capabilities  = caps_nxt;
        end else begin
          out_data_nxt.group_suite   = 3'd0;
          out_data_nxt.pairwise_mask = 6'd0;
          out_data_nxt.akm_mask      = 10'd0;
          out_data_nxt.capabilities  = 14'd0;
        end

        // drop all parse state for the next buffer
        byte_count_nxt   = 9'd0;
        tag_nxt          = 8'd0;
        len_nxt          = 8'd0;
        phase_nxt        = rsnep_pkg::PH_VERSION;
        fbi_nxt          = 2'd0;
        count_low_nxt    = 8'd0;
        suites_left_nxt  = 6'd0;
        prefix_match_nxt = 1'b1;
        error_nxt        = rsnep_pkg::ST_OK;
        group_nxt        = rsnep_pkg::GROUP_DEFAULT;
        pairwise_nxt     = rsnep_pkg::PAIRWISE_DEFAULT;
        akm_nxt          = rsnep_pkg::AKM_DEFAULT;
        caps_nxt         = 14'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= 9'd0;
      tag_r          <= 8'd0;
      len_r          <= 8'd0;
      phase_r        <= rsnep_pkg::PH_VERSION;
      fbi_r          <= 2'd0;
      count_low_r    <= 8'd0;
      suites_left_r  <= 6'd0;
      prefix_match_r <= 1'b1;
      error_r        <= rsnep_pkg::ST_OK;
      group_r        <= rsnep_pkg::GROUP_DEFAULT;
      pairwise_r     <= rsnep_pkg::PAIRWISE_DEFAULT;
      akm_r          <= rsnep_pkg::AKM_DEFAULT;
      caps_r         <= 14'd0;
      out_valid_r    <= 1'b0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      tag_r          <= tag_nxt;
      len_r          <= len_nxt;
      phase_r        <= phase_nxt;
      fbi_r          <= fbi_nxt;
      count_low_r    <= count_low_nxt;
      suites_left_r  <= suites_left_nxt;
      prefix_match_r <= prefix_match_nxt;
      error_r        <= error_nxt;
      group_r        <= group_nxt;
      pairwise_r     <= pairwise_nxt;
      akm_r          <= akm_nxt;
      caps_r         <= caps_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_byte |=> out_valid_r)
    else $error("last byte accepted without a result");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_byte |=> byte_count_r == 9'd0 &&
      phase_r == rsnep_pkg::PH_VERSION && error_r == rsnep_pkg::ST_OK)
    else $error("parser did not restart after last byte");

  a_error_zeroes_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != rsnep_pkg::ST_OK |->
      out_data_r.group_suite == 3'd0 && out_data_r.pairwise_mask == 6'd0 &&
      out_data_r.akm_mask == 10'd0 && out_data_r.capabilities == 14'd0)
    else $error("error verdict carries nonzero fields");

  a_done_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    error_r != rsnep_pkg::ST_OK |-> phase_r == rsnep_pkg::PH_DONE)
    else $error("latched error while parse still running");
`endif

endmodule

FILE: test/tb.sv
// Testbench for rsn_element_parser_top: random and directed RSN element buffers.
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTES_PER_PHASE = 120;
  // allowed suite types, one bit per type number
  localparam logic [7:0] GROUP_OK = 8'b1011_0110;
  localparam logic [5:0] PAIR_OK = 6'b11_0111;

  typedef enum int {SK_GROUP, SK_PAIRWISE, SK_AKM} suite_kind_t;

  class verdict_board_t;
    logic [8:0]        seen;
    logic [7:0]        tag_q;
    logic [7:0]        len_q;
    rsnep_pkg::phase_t phase_q;
    logic [1:0]        idx_q;
    logic [7:0]        lo_q;
    logic [5:0]        left_q;
    logic              prefix_ok;
    logic [2:0]        err_q;
    logic [2:0]        group_q;
    logic [5:0]        pair_q;
    logic [9:0]        akm_q;
    logic [13:0]       caps_q;
    rsnep_pkg::out_t   verdict_q[$];
    int                mismatches;
    int                verdicts_checked;
    int                status_tally[8];

    function new();
      mismatches = 0;
      verdicts_checked = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      clear_state();
    endfunction

    function void clear_state();
      seen = '0;
      tag_q = '0;
      len_q = '0;
      phase_q = rsnep_pkg::PH_VERSION;
      idx_q = '0;
      lo_q = '0;
      left_q = '0;
      prefix_ok = 1'b1;
      err_q = rsnep_pkg::ST_OK;
      group_q = rsnep_pkg::GROUP_DEFAULT;
      pair_q = rsnep_pkg::PAIRWISE_DEFAULT;
      akm_q = rsnep_pkg::AKM_DEFAULT;
      caps_q = '0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // keep the first error, stop parsing the body
    function void flag(logic [2:0] code);
      if (err_q == rsnep_pkg::ST_OK) err_q = code;
      phase_q = rsnep_pkg::PH_DONE;
    endfunction

    function void next_field(int unsigned rem_after, rsnep_pkg::phase_t nxt);
      idx_q = '0;
      phase_q = (rem_after == 0) ? rsnep_pkg::PH_DONE : nxt;
    endfunction

    // returns 1 on the type byte of a suite; tracks the prefix before it
    function bit suite_done(logic [7:0] b);
      logic [7:0] want;
      if (idx_q == 2'd0) prefix_ok = 1'b1;
      if (idx_q == 2'd3) return 1'b1;
      case (idx_q)
        2'd0:    want = rsnep_pkg::PREFIX_0;
        2'd1:    want = rsnep_pkg::PREFIX_1;
        default: want = rsnep_pkg::PREFIX_2;
      endcase
      if (b != want) prefix_ok = 1'b0;
      idx_q = idx_q + 2'd1;
      return 1'b0;
    endfunction

    function void note_byte(rsnep_pkg::in_t t);
      logic [7:0]      b;
      int unsigned     rem;
      int unsigned     rem_after;
      int unsigned     count;
      int unsigned     total;
      bit              first;
      bit              ok;
      logic [2:0]      st;
      rsnep_pkg::out_t exp;
      b = t.data_byte;
      if (seen == 0) begin
        tag_q = b;
      end else if (seen == 1) begin
        len_q = b;
        if (b < 2) flag(rsnep_pkg::ST_SHORT);
      end else if (seen < rsnep_pkg::HDR_LEN + len_q) begin
        rem = len_q - (seen - rsnep_pkg::HDR_LEN);
        rem_after = rem - 1;
        first = (idx_q == 2'd0);
        case (phase_q)
          rsnep_pkg::PH_VERSION: begin
            if (first) begin
              lo_q = b;
              idx_q = 2'd1;
            end else if ({b, lo_q} != rsnep_pkg::VERSION_ONE) begin
              flag(rsnep_pkg::ST_MALFORMED);
            end else begin
              next_field(rem_after, rsnep_pkg::PH_GROUP);
            end
          end
          rsnep_pkg::PH_GROUP: begin
            if (first && rem < 4) begin
              flag(rsnep_pkg::ST_MALFORMED);
            end else if (suite_done(b)) begin
              if (!prefix_ok || b > 8'd7 || !GROUP_OK[b[2:0]]) begin
                flag(rsnep_pkg::ST_SUITE);
              end else begin
                group_q = b[2:0];
                next_field(rem_after, rsnep_pkg::PH_PCOUNT);
              end
            end
          end
          rsnep_pkg::PH_PCOUNT, rsnep_pkg::PH_ACOUNT: begin
            if (first) begin
              if (rem < 2) flag(rsnep_pkg::ST_MALFORMED);
              else begin
                lo_q = b;
                idx_q = 2'd1;
              end
            end else begin
              count = {16'd0, b, lo_q};
              idx_q = '0;
              if (count == 0) flag(rsnep_pkg::ST_ZERO);
              else if (count * 4 > rem_after) flag(rsnep_pkg::ST_MALFORMED);
              else begin
                left_q = count[5:0];
                if (phase_q == rsnep_pkg::PH_PCOUNT) begin
                  pair_q = '0;
                  phase_q = rsnep_pkg::PH_PLIST;
                end else begin
                  akm_q = '0;
                  phase_q = rsnep_pkg::PH_ALIST;
                end
              end
            end
          end
          rsnep_pkg::PH_PLIST, rsnep_pkg::PH_ALIST: begin
            if (suite_done(b)) begin
              if (phase_q == rsnep_pkg::PH_PLIST) ok = (b <= 8'd5) && PAIR_OK[b[2:0]];
              else ok = (b >= 8'd1) && (b <= 8'd9);
              if (!prefix_ok || !ok) begin
                flag(rsnep_pkg::ST_SUITE);
              end else begin
                if (phase_q == rsnep_pkg::PH_PLIST) pair_q[b[2:0]] = 1'b1;
                else akm_q[b[3:0]] = 1'b1;
                idx_q = '0;
                left_q = left_q - 6'd1;
                if (left_q == 0)
                  next_field(rem_after, (phase_q == rsnep_pkg::PH_PLIST) ?
                             rsnep_pkg::PH_ACOUNT : rsnep_pkg::PH_CAPS);
              end
            end
          end
          rsnep_pkg::PH_CAPS: begin
            if (first) begin
              if (rem < 2) flag(rsnep_pkg::ST_MALFORMED);
              else begin
                caps_q = {6'd0, b};
                idx_q = 2'd1;
              end
            end else begin
              caps_q[13:9] = b[5:1];
              idx_q = '0;
              phase_q = rsnep_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
      if (seen < 9'd511) seen = seen + 9'd1;

      if (t.last_byte) begin
        total = {23'd0, seen};
        if (total < rsnep_pkg::HDR_LEN || total < rsnep_pkg::HDR_LEN + len_q)
          st = rsnep_pkg::ST_SHORT;
        else if (tag_q != rsnep_pkg::RSN_TAG) st = rsnep_pkg::ST_TAG;
        else st = err_q;
        exp = '0;
        exp.status = st;
        if (st == rsnep_pkg::ST_OK) begin
          exp.group_suite = group_q;
          exp.pairwise_mask = pair_q;
          exp.akm_mask = akm_q;
          exp.capabilities = caps_q;
        end
        status_tally[st]++;
        verdict_q.push_back(exp);
        clear_state();
      end
    endfunction

    function void check_verdict(rsnep_pkg::out_t got);
      rsnep_pkg::out_t exp;
      bit              bad;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected verdict: status %0d grp %0d pw %h akm %h caps %h",
                   $time, got.status, got.group_suite, got.pairwise_mask,
                   got.akm_mask, got.capabilities);
        return;
      end
      exp = verdict_q.pop_front();
      verdicts_checked++;
      bad = (got.status != exp.status) || (got.group_suite != exp.group_suite) ||
            (got.pairwise_mask != exp.pairwise_mask) || (got.akm_mask != exp.akm_mask) ||
            (got.capabilities != exp.capabilities);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] verdict mismatch #%0d", $time, verdicts_checked);
          $display("  expected: status %0d grp %0d pw %h akm %h caps %h", exp.status,
                   exp.group_suite, exp.pairwise_mask, exp.akm_mask, exp.capabilities);
          $display("  actual:   status %0d grp %0d pw %h akm %h caps %h", got.status,
                   got.group_suite, got.pairwise_mask, got.akm_mask, got.capabilities);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rsnep_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  rsnep_pkg::out_t out_data;

  verdict_board_t board;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  logic [7:0] frame_q[$];
  logic [7:0] elem_q[$];

  rsn_element_parser_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, board.pending());
      $display("** rsn_element_parser_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_verdict(out_data);
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    rsnep_pkg::in_t t;
    t.data_byte = b;
    t.last_byte = last;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    // hold the transaction until it is taken
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_byte(t);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    buffers_sent++;
  endtask

  // drop valid, then wait for every outstanding verdict
  task automatic drain_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic add_suite(input suite_kind_t kind);
    logic [7:0] t;
    if ($urandom_range(0, 99) < 88) begin
      case (kind)
        SK_GROUP: begin
          case ($urandom_range(0, 4))
            0: t = 8'd1;
            1: t = 8'd2;
            2: t = 8'd4;
            3: t = 8'd5;
            default: t = 8'd7;
          endcase
        end
        SK_PAIRWISE: begin
          case ($urandom_range(0, 4))
            0: t = 8'd0;
            1: t = 8'd1;
            2: t = 8'd2;
            3: t = 8'd4;
            default: t = 8'd5;
          endcase
        end
        default: t = 8'($urandom_range(1, 9));
      endcase
    end else begin
      t = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    end
    elem_q.push_back(rsnep_pkg::PREFIX_0);
    elem_q.push_back(rsnep_pkg::PREFIX_1);
    elem_q.push_back(rsnep_pkg::PREFIX_2);
    elem_q.push_back(t);
    if ($urandom_range(0, 99) < 4)
      elem_q[elem_q.size() - 1 - $urandom_range(1, 3)] = 8'($urandom_range(0, 255));
  endtask

  task automatic add_count(input int unsigned n);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'(n);
    hi = 8'd0;
    case ($urandom_range(0, 49))
      0, 1, 2: lo = 8'd0;
      3, 4:    hi = 8'($urandom_range(1, 255));
      5, 6:    lo = 8'(n + $urandom_range(1, 3));
      default: ;
    endcase
    elem_q.push_back(lo);
    elem_q.push_back(hi);
  endtask

  // proper element with random content, then cuts, mutations and trailing bytes
  task automatic build_frame();
    int unsigned np;
    int unsigned na;
    int unsigned cut;
    int unsigned at_group;
    int unsigned at_pcount;
    int unsigned at_acount;
    int unsigned at_caps;
    int unsigned k;
    np = ($urandom_range(0, 24) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3);
    na = ($urandom_range(0, 24) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3);
    elem_q = {};
    elem_q.push_back(rsnep_pkg::VERSION_ONE[7:0]);
    elem_q.push_back(rsnep_pkg::VERSION_ONE[15:8]);
    at_group = elem_q.size();
    add_suite(SK_GROUP);
    at_pcount = elem_q.size();
    add_count(np);
    repeat (np) add_suite(SK_PAIRWISE);
    at_acount = elem_q.size();
    add_count(na);
    repeat (na) add_suite(SK_AKM);
    at_caps = elem_q.size();
    elem_q.push_back(8'($urandom_range(0, 255)));
    elem_q.push_back(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      0:       cut = at_group;
      1:       cut = at_pcount;
      2:       cut = at_acount;
      3:       cut = at_caps;
      4:       cut = $urandom_range(0, elem_q.size());
      default: cut = elem_q.size();
    endcase
    while (elem_q.size() > cut) void'(elem_q.pop_back());
    // padding inside the element, after the last byte that the cut kept
    if ($urandom_range(0, 19) == 0) begin
      k = $urandom_range(1, 8);
      while (k > 0 && elem_q.size() < 255) begin
        elem_q.push_back(8'($urandom_range(0, 255)));
        k--;
      end
    end
    frame_q = {};
    frame_q.push_back(rsnep_pkg::RSN_TAG);
    frame_q.push_back(8'(elem_q.size()));
    foreach (elem_q[i]) frame_q.push_back(elem_q[i]);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: frame_q[0] = 8'($urandom_range(0, 255));
        1: frame_q[1] = 8'($urandom_range(0, 255));
        2: frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
        default: begin
          k = $urandom_range(1, frame_q.size());
          while (frame_q.size() > k) void'(frame_q.pop_back());
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned phase_start;
    board = new();
    cycles = 0;
    bytes_sent = 0;
    buffers_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single byte: nothing past the buffer is read
    frame_q = {rsnep_pkg::RSN_TAG};
    send_frame();
    // zero length
    frame_q = {rsnep_pkg::RSN_TAG, 8'd0};
    send_frame();
    // wrong tag over a valid body
    frame_q = {8'hff, 8'd2, 8'd1, 8'd0};
    send_frame();
    // element runs past the buffer
    frame_q = {rsnep_pkg::RSN_TAG, 8'd6, 8'd1, 8'd0};
    send_frame();
    // group suite cut off
    frame_q = {rsnep_pkg::RSN_TAG, 8'd3, 8'd1, 8'd0, 8'd0};
    send_frame();
    // bad version, trailing byte ignored
    frame_q = {rsnep_pkg::RSN_TAG, 8'd2, 8'hff, 8'hff, 8'h00};
    send_frame();
    drain_verdicts();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        build_frame();
        send_frame();
      end
      // hold the sender until the receiver has caught up
      drain_verdicts();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("sent %0d buffers (%0d bytes) through four idle/stall mixes; %0d verdicts checked",
             buffers_sent, bytes_sent, board.verdicts_checked);
    $display("statuses ok %0d, short %0d, tag %0d, malformed %0d, suite %0d, zero count %0d",
             board.status_tally[rsnep_pkg::ST_OK], board.status_tally[rsnep_pkg::ST_SHORT],
             board.status_tally[rsnep_pkg::ST_TAG],
             board.status_tally[rsnep_pkg::ST_MALFORMED],
             board.status_tally[rsnep_pkg::ST_SUITE], board.status_tally[rsnep_pkg::ST_ZERO]);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** rsn_element_parser_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", board.mismatches, board.pending());
      $display("** rsn_element_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
